>>> rtl/core/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared constants, codes and types of the frame slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int GRP_SIZE      = 8;

    localparam logic [6:0]  CAP_RESET = 7'd64;
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic is_free;
        logic swap;
    } t_cell_ctrl;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

>>> rtl/core/frame_slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// frame_slot_pool_allocator
// Fixed pool of buffer slots kept as an ordering table in a row of cells.
// Allocate hands out the first free entry; free swaps the slot with the
// last allocated entry. Reports count, peak and saturating event counters.
//
//   channel   signals                                 direction
//   request   i_valid / o_stall, i_operation,         in
//             i_slot_number
//   result    o_valid / i_stall, o_status, ...        out
//   config    i_cfg_we, i_cfg_data (pool_capacity)    in
//
// An item goes through accept, cell compare and group merge, merge across
// groups, table update and result write; o_stall holds off a new request
// until then. Reset is synchronous and restores the table to entry i = slot i.
// A result waiting on i_stall does not block the next accept; a new result
// waits in the update cycle until the output register is free.
// ----------------------------------------------------------------------------
module frame_slot_pool_allocator #(
    parameter int MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [5:0]  i_slot_number,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_granted_slot,
    output logic [6:0]  o_slots_in_use,
    output logic [6:0]  o_peak_in_use,
    output logic [31:0] o_allocation_count,
    output logic [31:0] o_free_count,
    output logic [31:0] o_exhaustion_count
);

    localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int PICK_W  = (IDX_W > 6) ? IDX_W : 6;
    localparam int GRP     = fspa_pkg::GRP_SIZE;
    localparam int NUM_GRP = (MAX_SLOTS + GRP - 1) / GRP;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_GATHER = 4'b0100,
        S_APPLY  = 4'b1000
    } t_state;

    t_state               r_state;
    logic                 r_op;
    logic [5:0]           r_slot;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_peak;
    logic [6:0]           r_cap;
    logic [31:0]          r_alloc;
    logic [31:0]          r_free;
    logic [31:0]          r_exh;
    logic [IDX_W-1:0]     r_grp_val [NUM_GRP];
    logic                 r_grp_hit [NUM_GRP];
    logic [IDX_W-1:0]     r_pick;
    logic                 r_found;
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [5:0]           r_granted;
    logic [6:0]           r_used;
    logic [6:0]           r_peak_out;

    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_peak;
    logic [31:0]          n_alloc;
    logic [31:0]          n_free;
    logic [31:0]          n_exh;
    logic [IDX_W-1:0]     n_grp_val [NUM_GRP];
    logic                 n_grp_hit [NUM_GRP];
    logic [IDX_W-1:0]     n_pick;
    logic                 n_found;
    logic [1:0]           n_status;
    logic [5:0]           n_granted;

    logic [IDX_W-1:0]     w_sel_val [MAX_SLOTS];
    logic                 w_hit     [MAX_SLOTS];
    fspa_pkg::t_cell_ctrl cell_ctrl;
    logic                 out_free;
    logic                 commit;
    logic                 full;
    logic [PICK_W-1:0]    pick_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     peak_ext;

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign commit   = (r_state == S_APPLY) && out_free;

    assign cell_ctrl.is_free = (r_op == fspa_pkg::OP_FREE);
    assign cell_ctrl.swap    = commit && (r_op == fspa_pkg::OP_FREE) && r_found;

    for (genvar gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
        fspa_cell #(
            .MAX_SLOTS (MAX_SLOTS),
            .CELL_IDX  (gi)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (cell_ctrl),
            .i_count   (r_count),
            .i_slot    (r_slot),
            .i_pick    (r_pick),
            .o_sel_val (w_sel_val[gi]),
            .o_hit     (w_hit[gi])
        );
    end

    // merge cell outputs within each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp_val[g] = '0;
            n_grp_hit[g] = 1'b0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < MAX_SLOTS) begin
                    n_grp_val[g] = n_grp_val[g] | w_sel_val[g * GRP + k];
                    n_grp_hit[g] = n_grp_hit[g] | w_hit[g * GRP + k];
                end
            end
        end
    end

    // merge across groups
    always_comb begin
        n_pick  = '0;
        n_found = 1'b0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_pick  = n_pick | r_grp_val[g];
            n_found = n_found | r_grp_hit[g];
        end
    end

    assign full = (CMP_W'(r_count) >= CMP_W'(r_cap)) ||
                  (CMP_W'(r_count) >= CMP_W'(MAX_SLOTS));
    assign pick_ext = PICK_W'(r_pick);

    always_comb begin
        n_count   = r_count;
        n_peak    = r_peak;
        n_alloc   = r_alloc;
        n_free    = r_free;
        n_exh     = r_exh;
        n_status  = fspa_pkg::ST_OK;
        n_granted = '0;
        unique case (r_op)
            fspa_pkg::OP_ALLOC: begin
                if (full) begin
                    n_exh    = fspa_pkg::sat_inc(r_exh);
                    n_status = fspa_pkg::ST_EXHAUSTED;
                end else begin
                    n_granted = pick_ext[5:0];
                    n_count   = r_count + CNT_W'(1);
                    n_alloc   = fspa_pkg::sat_inc(r_alloc);
                    if (n_count > r_peak) begin
                        n_peak = n_count;
                    end
                end
            end
            fspa_pkg::OP_FREE: begin
                if (r_found) begin
                    n_count = r_count - CNT_W'(1);
                    n_free  = fspa_pkg::sat_inc(r_free);
                end else begin
                    n_status = fspa_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = fspa_pkg::ST_OK;
            end
        endcase
    end

    assign cnt_ext  = CMP_W'(n_count);
    assign peak_ext = CMP_W'(n_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_peak      <= '0;
            r_cap       <= fspa_pkg::CAP_RESET;
            r_alloc     <= '0;
            r_free      <= '0;
            r_exh       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_GATHER;
                end
                S_GATHER: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (commit) begin
                r_count     <= n_count;
                r_peak      <= n_peak;
                r_alloc     <= n_alloc;
                r_free      <= n_free;
                r_exh       <= n_exh;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op   <= i_operation;
            r_slot <= i_slot_number;
        end
        if (r_state == S_LOOK) begin
            r_grp_val <= n_grp_val;
            r_grp_hit <= n_grp_hit;
        end
        if (r_state == S_GATHER) begin
            r_pick  <= n_pick;
            r_found <= n_found;
        end
        if (commit) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_used     <= cnt_ext[6:0];
            r_peak_out <= peak_ext[6:0];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_granted_slot     = r_granted;
    assign o_slots_in_use     = r_used;
    assign o_peak_in_use      = r_peak_out;
    assign o_allocation_count = r_alloc;
    assign o_free_count       = r_free;
    assign o_exhaustion_count = r_exh;

endmodule

>>> rtl/core/fspa_cell.sv
// ----------------------------------------------------------------------------
// fspa_cell
// One entry of the slot ordering table: holds a slot number, matches it
// against a freed slot and offers it when it sits at the head or tail.
// ----------------------------------------------------------------------------
module fspa_cell #(
    parameter int  MAX_SLOTS = fspa_pkg::MAX_SLOTS_DEF,
    parameter int  CELL_IDX  = 0,
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fspa_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [5:0]              i_slot,
    input  logic [IDX_W-1:0]        i_pick,
    output logic [IDX_W-1:0]        o_sel_val,
    output logic                    o_hit
);

    localparam int PICK_W = (IDX_W > 6) ? IDX_W : 6;

    logic [IDX_W-1:0]  r_value;
    logic [IDX_W-1:0]  n_value;
    logic [PICK_W-1:0] slot_ext;
    logic [PICK_W-1:0] val_ext;
    logic              is_last;
    logic              is_head;
    logic              in_use;

    assign is_last  = (i_count == CNT_W'(CELL_IDX + 1));
    assign is_head  = (i_count == CNT_W'(CELL_IDX));
    assign in_use   = (i_count >  CNT_W'(CELL_IDX));
    assign slot_ext = PICK_W'(i_slot);
    assign val_ext  = PICK_W'(r_value);

    assign o_hit     = in_use && (val_ext == slot_ext);
    // allocate reads the first free entry, free reads the last allocated one
    assign o_sel_val = (i_ctrl.is_free ? is_last : is_head) ? r_value : '0;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.swap) begin
            priority if (o_hit) begin
                n_value = i_pick;
            end else if (is_last) begin
                n_value = slot_ext[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= IDX_W'(CELL_IDX);
        end else begin
            r_value <= n_value;
        end
    end

endmodule

>>> test/fspa_pool_checker.sv
// ----------------------------------------------------------------------------
// fspa_pool_checker
// Watches the request, result and configuration ports of the slot pool
// allocator, keeps its own copy of the ordering table and statistics, and
// compares every result transfer field by field with the predicted one.
// ----------------------------------------------------------------------------
module fspa_pool_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_req_operation,
    input  logic [5:0]  i_req_slot,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_res_status,
    input  logic [5:0]  i_res_granted,
    input  logic [6:0]  i_res_in_use,
    input  logic [6:0]  i_res_peak,
    input  logic [31:0] i_res_allocs,
    input  logic [31:0] i_res_frees,
    input  logic [31:0] i_res_exhausts,
    output int          o_mismatches,
    output int          o_pending,
    output logic [63:0] o_held_slots
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = fspa_pkg::MAX_SLOTS_DEF;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  granted;
        logic [6:0]  in_use;
        logic [6:0]  peak;
        logic [31:0] allocs;
        logic [31:0] frees;
        logic [31:0] exhausts;
    } t_pool_result;

    logic [5:0]  slot_table [SLOTS];
    logic [6:0]  in_use_count;
    logic [6:0]  peak_count;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
    logic [31:0] exhaust_total;
    logic [6:0]  capacity;
    logic [63:0] held_slots;
    t_pool_result owed_results [$];
    int mismatches = 0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == fspa_pkg::CNT_MAX) ? v : v + 32'd1;
    endfunction

    task automatic clear_pool();
        for (int i = 0; i < SLOTS; i++) slot_table[i] = 6'(i);
        in_use_count  = '0;
        peak_count    = '0;
        alloc_total   = '0;
        free_total    = '0;
        exhaust_total = '0;
        capacity      = fspa_pkg::CAP_RESET;
        held_slots    = '0;
    endtask

    task automatic apply_request(input logic op, input logic [5:0] slot,
                                 output t_pool_result res);
        logic [6:0] limit;
        logic [5:0] moved;
        int         last;
        bit         found;
        limit = (capacity > 7'(SLOTS)) ? 7'(SLOTS) : capacity;
        found = 1'b0;
        res.status  = fspa_pkg::ST_OK;
        res.granted = '0;
        if (op == fspa_pkg::OP_ALLOC) begin
            if (in_use_count >= limit) begin
                exhaust_total = bump(exhaust_total);
                res.status    = fspa_pkg::ST_EXHAUSTED;
            end else begin
                res.granted = slot_table[in_use_count[5:0]];
                held_slots[res.granted] = 1'b1;
                in_use_count = in_use_count + 7'd1;
                alloc_total  = bump(alloc_total);
                if (in_use_count > peak_count) peak_count = in_use_count;
            end
        end else begin
            // search the whole allocated part, even above a lowered capacity
            for (int i = 0; i < int'(in_use_count) && !found; i++) begin
                if (slot_table[i] == slot) begin
                    last             = int'(in_use_count) - 1;
                    moved            = slot_table[last];
                    slot_table[last] = slot_table[i];
                    slot_table[i]    = moved;
                    found            = 1'b1;
                end
            end
            if (found) begin
                held_slots[slot] = 1'b0;
                in_use_count     = in_use_count - 7'd1;
                free_total       = bump(free_total);
            end else begin
                res.status = fspa_pkg::ST_NOT_FOUND;
            end
        end
        res.in_use   = in_use_count;
        res.peak     = peak_count;
        res.allocs   = alloc_total;
        res.frees    = free_total;
        res.exhausts = exhaust_total;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s mismatch: got %0d, expected %0d",
                                      name, got, want));
    endtask

    always @(posedge i_clk) begin : watch_ports
        t_pool_result want;
        if (!i_rst_n) begin
            clear_pool();
            owed_results.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_data;
            // retire the older result before queueing the new request
            if (i_res_valid && !i_res_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", 32'(i_res_status), 32'(want.status));
                    check_field("granted_slot", 32'(i_res_granted),
                                32'(want.granted));
                    check_field("slots_in_use", 32'(i_res_in_use), 32'(want.in_use));
                    check_field("peak_in_use", 32'(i_res_peak), 32'(want.peak));
                    check_field("allocation_count", i_res_allocs, want.allocs);
                    check_field("free_count", i_res_frees, want.frees);
                    check_field("exhaustion_count", i_res_exhausts, want.exhausts);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                apply_request(i_req_operation, i_req_slot, want);
                owed_results.push_back(want);
            end
        end
        o_pending    = owed_results.size();
        o_held_slots = held_slots;
        o_mismatches = mismatches;
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the frame slot pool allocator. Runs a directed
// sequence over empty, partial, lowered and zero capacity, then random phases
// of allocate and free traffic under several capacities with random idling.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 14;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [5:0]  i_slot_number;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [5:0]  o_granted_slot;
    logic [6:0]  o_slots_in_use;
    logic [6:0]  o_peak_in_use;
    logic [31:0] o_allocation_count;
    logic [31:0] o_free_count;
    logic [31:0] o_exhaustion_count;

    int          mismatches;
    int          pending;
    logic [63:0] held_slots;
    int          gap_pct;
    int          stall_pct;
    int          quiet_cycles;

    frame_slot_pool_allocator DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_slot_number      (i_slot_number),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_granted_slot     (o_granted_slot),
        .o_slots_in_use     (o_slots_in_use),
        .o_peak_in_use      (o_peak_in_use),
        .o_allocation_count (o_allocation_count),
        .o_free_count       (o_free_count),
        .o_exhaustion_count (o_exhaustion_count)
    );

    fspa_pool_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_operation (i_operation),
        .i_req_slot      (i_slot_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_status    (o_status),
        .i_res_granted   (o_granted_slot),
        .i_res_in_use    (o_slots_in_use),
        .i_res_peak      (o_peak_in_use),
        .i_res_allocs    (o_allocation_count),
        .i_res_frees     (o_free_count),
        .i_res_exhausts  (o_exhaustion_count),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_held_slots    (held_slots)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: random stall bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold the payload until the transfer, then return at the next falling edge
    // with valid still high; the caller lowers it when traffic pauses.
    task automatic send_request(input logic op, input logic [5:0] slot);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_operation   = op;
        i_slot_number = slot;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_pool_traffic();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [6:0] value);
        drain_pool_traffic();
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [5:0] pick_held_slot(input logic [63:0] held);
        int start;
        start = $urandom_range(0, 63);
        for (int k = 0; k < 64; k++)
            if (held[(start + k) % 64]) return 6'((start + k) % 64);
        return 6'(start);
    endfunction

    function automatic logic [6:0] pick_capacity();
        logic [6:0] menu [12];
        menu = '{7'd0, 7'd1, 7'd2, 7'd5, 7'd17, 7'd32, 7'd63, 7'd64, 7'd65,
                 7'd100, 7'd127, 7'd0};
        menu[11] = 7'($urandom_range(0, 127));
        return menu[$urandom_range(0, 11)];
    endfunction

    initial begin
        int alloc_pct;
        int phase_len;
        logic [6:0] pct_menu [4];
        pct_menu = '{7'd30, 7'd50, 7'd65, 7'd80};

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = fspa_pkg::OP_ALLOC;
        i_slot_number = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = fspa_pkg::CAP_RESET;
        gap_pct       = 0;
        stall_pct     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pool, swap from the middle, double free, ends of table
        gap_pct   = 20;
        stall_pct = 10;
        send_request(fspa_pkg::OP_FREE, 6'd0);
        send_request(fspa_pkg::OP_FREE, 6'd63);
        repeat (4) send_request(fspa_pkg::OP_ALLOC, 6'd63);
        send_request(fspa_pkg::OP_FREE, 6'd1);
        send_request(fspa_pkg::OP_FREE, 6'd1);
        send_request(fspa_pkg::OP_FREE, 6'd63);
        send_request(fspa_pkg::OP_ALLOC, 6'd0);
        send_request(fspa_pkg::OP_FREE, 6'd0);
        send_request(fspa_pkg::OP_FREE, 6'd1);

        // capacity lowered below the count: refuse allocs, frees still search
        set_capacity(7'd1);
        send_request(fspa_pkg::OP_ALLOC, 6'd0);
        send_request(fspa_pkg::OP_FREE, 6'd3);
        send_request(fspa_pkg::OP_ALLOC, 6'd0);
        send_request(fspa_pkg::OP_FREE, 6'd2);
        send_request(fspa_pkg::OP_ALLOC, 6'd42);
        set_capacity(7'd0);
        send_request(fspa_pkg::OP_ALLOC, 6'd0);
        send_request(fspa_pkg::OP_FREE, pick_held_slot(held_slots));
        send_request(fspa_pkg::OP_ALLOC, 6'd21);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                set_capacity(7'd127);   // above the table size: fill to the top
                alloc_pct = 100;
                phase_len = 70;
            end else if (ph == 1) begin
                set_capacity(7'd64);
                alloc_pct = 0;          // drain, then free on an empty pool
                phase_len = 70;
            end else begin
                set_capacity(pick_capacity());
                alloc_pct = int'(pct_menu[$urandom_range(0, 3)]);
                phase_len = 130;
            end
            if (ph >= PHASES - 2) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            end
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(0, 99) < alloc_pct)
                    send_request(fspa_pkg::OP_ALLOC, 6'($urandom));
                else if ($urandom_range(0, 99) < 85)
                    send_request(fspa_pkg::OP_FREE, pick_held_slot(held_slots));
                else
                    send_request(fspa_pkg::OP_FREE, 6'($urandom));
            end
        end

        drain_pool_traffic();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
